// ----- hw/rtl/vib_pkg.sv -----
// Shared types, register codes, reset values and the cosine table of the vibrato block.
package vib_pkg;

	// Cosine quarter-wave table geometry (entries 0..COS_TABLE_SIZE, power of two)
	localparam int COS_TABLE_SIZE = 256;
	localparam int COS_IDX_W      = $clog2(COS_TABLE_SIZE);

	// Configuration data width (widest register)
	localparam int CFG_DATA_W = 32;

	// Register indexes
	typedef enum logic [1:0] {
		CFG_ENABLE    = 2'd0,
		CFG_PHASE_STEP = 2'd1,
		CFG_DEPTH     = 2'd2,
		CFG_MAX_DELAY = 2'd3
	} cfg_idx_t;

	// Register reset values
	localparam logic        RST_ENABLE     = 1'b0;
	localparam logic [31:0] RST_PHASE_STEP = 32'd486957;
	localparam logic [16:0] RST_DEPTH      = 17'd32768;
	localparam logic [9:0]  RST_MAX_DELAY  = 10'd220;

	// Depth limit (100 percent in Q1.16) and one in Q2.31
	localparam logic [16:0] DEPTH_FULL = 17'd65536;
	localparam logic [32:0] ONE_Q31    = 33'h0_8000_0000;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_READ,
		ST_DONE
	} state_t;

	// Taylor series divisors (2n-1)*(2n) for n = 1..9
	typedef int taylor_div_t [1:9];
	localparam taylor_div_t TaylorDiv = '{2, 12, 30, 56, 90, 132, 182, 240, 306};

	typedef logic [15:0] cos_tab_t [0:COS_TABLE_SIZE];

	// Build the Q15 quarter-wave cosine table from a truncated Q30 Taylor sum
	function automatic cos_tab_t build_cos_tab();
		cos_tab_t    t;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] mag;
		longint      sum;
		longint      q;
		for (int k = 0; k <= COS_TABLE_SIZE; k++) begin
			x   = (64'd1686629713 * 64'(k)) / COS_TABLE_SIZE;
			x2  = (x * x) >> 30;
			mag = 64'd1 << 30;
			sum = longint'(mag);
			for (int n = 1; n <= 9; n++) begin
				mag = ((mag * x2) >> 30) / TaylorDiv[n];
				if ((n % 2) == 1) begin
					sum = sum - longint'(mag);
				end else begin
					sum = sum + longint'(mag);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			q = (sum + 16384) >>> 15;
			if (q > 32768) begin
				q = 32768;
			end
			t[k] = 16'(q);
		end
		return t;
	endfunction

	localparam cos_tab_t COS_TAB = build_cos_tab();

endpackage

// ----- hw/rtl/vib_in_if.sv -----
// Input stream channel of the vibrato block: one raw sample per item.
interface vib_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

// ----- hw/rtl/vib_out_if.sv -----
// Output stream channel of the vibrato block: one delayed sample per item.
interface vib_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink   (input valid, input sample_out, output ready);
endinterface

// ----- hw/rtl/vib_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
module vib_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, hold data when not reading
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hw/rtl/lfo_modulated_delay_vibrato.sv -----
// Top level of the cosine-LFO vibrato: sequencer, shared multiplier and delay ring.
//
// Usage:
//   in_ch carries one raw 16-bit sample per item, out_ch one delayed sample per item;
//   both move an item when valid and ready are high at a rising clock edge.
//   The plain write port (cfg_we, cfg_index, cfg_data) sets enable, phase_step,
//   depth_fraction and max_delay_samples; write it only while the block is idle.
//   With the effect on, an accepted item passes through the steps MUL1, MUL2, READ
//   and DONE before the next ready: one 33x17 multiplier is used twice (depth times
//   cosine, then one minus that times half the maximum delay), and the ring read takes
//   its own step for its registered port. The result is loaded into the output register
//   as DONE finishes. In bypass an item goes straight from acceptance to DONE.
//   in_ch.ready is high only while the sequencer waits for an item. A finished
//   result sits in an output register; the next item is taken and computed while
//   it waits, and the sequencer holds in its last step only if the result before
//   has not yet been taken.
//   Reset clears the registers to their defaults, the write pointer and LFO phase
//   to zero; a fill count makes unwritten ring entries read as zero, so no
//   clearing pass is needed and the block is ready right after reset.
module lfo_modulated_delay_vibrato #(
	parameter int RING_DEPTH = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	vib_in_if.sink                        in_ch,
	vib_out_if.source                     out_ch,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [vib_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int PTR_W = $clog2(RING_DEPTH);
	localparam int COS_IDX_LW = vib_pkg::COS_IDX_W;

	vib_pkg::state_t state_q, state_n;

	// Configuration registers
	logic        enable_q;
	logic [31:0] phase_step_q;
	logic [16:0] depth_q;
	logic [9:0]  max_delay_q;

	// Block state
	logic [31:0]    phase_q;
	logic [PTR_W-1:0] wp_q;
	logic [PTR_W:0]   fill_q;

	// Per-item registers
	logic [15:0]      x_q;
	logic             byp_q;
	logic [32:0]      onem_q;
	logic [PTR_W-1:0] d_q;
	logic             rd_ok_q;
	logic [15:0]      cos_mag_q;
	logic             cos_neg_q;

	// Output register
	logic        out_valid_q;
	logic [15:0] out_data_q;

	// Control
	logic             in_fire;
	logic             done_fire;
	logic             ram_re;
	logic [32:0]      mul_a;
	logic [16:0]      mul_b;
	logic [49:0]      mul_p;
	logic [16:0]      depth_sat;
	logic [32:0]      onem_n;
	logic [19:0]      d_full;
	logic [PTR_W-1:0] d_sat;
	logic [PTR_W-1:0] rd_addr;
	logic             rd_ok;
	logic [15:0]      ram_rdata;

	// Cosine lookup
	logic [1:0]           quad;
	logic [COS_IDX_LW:0]  idx;
	logic [COS_IDX_LW:0]  rev;

	assign quad = phase_q[31:30];
	assign idx  = {1'b0, phase_q[29 -: vib_pkg::COS_IDX_W]};
	assign rev  = (vib_pkg::COS_IDX_W + 1)'(vib_pkg::COS_TABLE_SIZE) - idx;

	// Track the cosine of the current phase every cycle
	always_ff @(posedge clk) begin
		if (quad == 2'd0 || quad == 2'd2) begin
			cos_mag_q <= vib_pkg::COS_TAB[idx];
		end else begin
			cos_mag_q <= vib_pkg::COS_TAB[rev];
		end
		cos_neg_q <= (quad == 2'd1) || (quad == 2'd2);
	end

	// Handshake qualifiers
	assign in_fire   = in_ch.valid && in_ch.ready;
	assign done_fire = (state_q == vib_pkg::ST_DONE) && (!out_valid_q || out_ch.ready);

	// Next-state logic
	always_comb begin
		state_n = state_q;
		case (state_q)
			vib_pkg::ST_IDLE: begin
				if (in_fire) begin
					state_n = enable_q ? vib_pkg::ST_MUL1 : vib_pkg::ST_DONE;
				end
			end
			vib_pkg::ST_MUL1: state_n = vib_pkg::ST_MUL2;
			vib_pkg::ST_MUL2: state_n = vib_pkg::ST_READ;
			vib_pkg::ST_READ: state_n = vib_pkg::ST_DONE;
			vib_pkg::ST_DONE: begin
				if (done_fire) begin
					state_n = vib_pkg::ST_IDLE;
				end
			end
			default: state_n = vib_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs: channel ready, multiplier operands, ring read
	always_comb begin
		in_ch.ready = 1'b0;
		ram_re      = 1'b0;
		mul_a       = {17'b0, cos_mag_q};
		mul_b       = depth_sat;
		case (state_q)
			vib_pkg::ST_IDLE: in_ch.ready = 1'b1;
			vib_pkg::ST_MUL1: begin
				mul_a = {17'b0, cos_mag_q};
				mul_b = depth_sat;
			end
			vib_pkg::ST_MUL2: begin
				mul_a = onem_q;
				mul_b = {8'b0, max_delay_q[9:1]};
			end
			vib_pkg::ST_READ: ram_re = 1'b1;
			vib_pkg::ST_DONE: ram_re = 1'b0;
			default: ram_re = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vib_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Shared multiplier
	assign mul_p     = mul_a * mul_b;
	assign depth_sat = (depth_q > vib_pkg::DEPTH_FULL) ? vib_pkg::DEPTH_FULL : depth_q;

	// One minus depth times cosine, Q2.31
	assign onem_n = cos_neg_q ? (vib_pkg::ONE_Q31 + mul_p[32:0])
	                          : (vib_pkg::ONE_Q31 - mul_p[32:0]);

	// Delay from the second product, clamped to the ring
	assign d_full = 20'(mul_p[49:31]) + 20'd1;
	assign d_sat  = (d_full > 20'(RING_DEPTH - 1)) ? PTR_W'(RING_DEPTH - 1)
	                                               : d_full[PTR_W-1:0];

	// Read address behind the write pointer, wrapped into the ring
	assign rd_addr = wp_q - d_q + ((wp_q < d_q) ? PTR_W'(RING_DEPTH) : PTR_W'(0));
	assign rd_ok   = fill_q >= {1'b0, d_q};

	// Per-item datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			x_q   <= in_ch.sample_in;
			byp_q <= !enable_q;
		end
		if (state_q == vib_pkg::ST_MUL1) begin
			onem_q <= onem_n;
		end
		if (state_q == vib_pkg::ST_MUL2) begin
			d_q <= d_sat;
		end
		if (state_q == vib_pkg::ST_READ) begin
			rd_ok_q <= rd_ok;
		end
	end

	// Advance write pointer and fill count when an item finishes, and the phase unless bypassed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 32'd0;
			wp_q    <= '0;
			fill_q  <= '0;
		end else if (done_fire) begin
			if (!byp_q) begin
				phase_q <= phase_q + phase_step_q;
			end
			wp_q <= (wp_q == PTR_W'(RING_DEPTH - 1)) ? PTR_W'(0) : wp_q + PTR_W'(1);
			if (fill_q != (PTR_W + 1)'(RING_DEPTH)) begin
				fill_q <= fill_q + (PTR_W + 1)'(1);
			end
		end
	end

	// Output register: load on finish, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_fire) begin
			if (byp_q) begin
				out_data_q <= x_q;
			end else begin
				out_data_q <= rd_ok_q ? ram_rdata : 16'd0;
			end
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.sample_out = out_data_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q     <= vib_pkg::RST_ENABLE;
			phase_step_q <= vib_pkg::RST_PHASE_STEP;
			depth_q      <= vib_pkg::RST_DEPTH;
			max_delay_q  <= vib_pkg::RST_MAX_DELAY;
		end else if (cfg_we) begin
			case (vib_pkg::cfg_idx_t'(cfg_index))
				vib_pkg::CFG_ENABLE:     enable_q     <= cfg_data[0];
				vib_pkg::CFG_PHASE_STEP: phase_step_q <= cfg_data[31:0];
				vib_pkg::CFG_DEPTH:      depth_q      <= cfg_data[16:0];
				vib_pkg::CFG_MAX_DELAY:  max_delay_q  <= cfg_data[9:0];
				default:                 enable_q     <= enable_q;
			endcase
		end
	end

	// Delay ring
	vib_ram #(
		.WIDTH (16),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (done_fire),
		.waddr (wp_q),
		.wdata (x_q),
		.re    (ram_re),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

endmodule

// ----- tb/lfo_modulated_delay_vibrato_tb.sv -----
// Testbench for the cosine-LFO vibrato: stream stimulus, scoreboard and self-check.
`timescale 1ns / 100ps

module lfo_modulated_delay_vibrato_tb;

	localparam int DEPTH_RING  = 1024;
	localparam int TAB_SIZE    = 256;
	localparam int ITEM_TARGET = 1550;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYC  = 12;

	// Tracks the delay ring and LFO and predicts each delayed sample
	class vibrato_tracker;
		int          cos_q15 [0:TAB_SIZE];
		logic [15:0] ring [0:DEPTH_RING-1];
		logic [9:0]  wr_ptr;
		logic [31:0] lfo_phase;
		logic        fx_on;
		logic [31:0] step;
		logic [16:0] depth;
		logic [9:0]  max_delay;
		logic [15:0] expected_out [$];
		int          errors;
		int          wet_cnt;
		int          dry_cnt;

		function new();
			longint unsigned x;
			longint unsigned x2;
			longint unsigned mag;
			longint          acc;
			longint          q;
			// Quarter-wave cosine in Q15 from a truncated Q30 Taylor sum
			for (int k = 0; k <= TAB_SIZE; k++) begin
				x   = (64'd1686629713 * longint'(k)) / TAB_SIZE;
				x2  = (x * x) >> 30;
				mag = 64'd1 << 30;
				acc = longint'(mag);
				for (int n = 1; n <= 9; n++) begin
					mag = ((mag * x2) >> 30) / longint'((2 * n - 1) * (2 * n));
					if (n % 2 == 1) begin
						acc = acc - longint'(mag);
					end else begin
						acc = acc + longint'(mag);
					end
				end
				if (acc < 0) begin
					acc = 0;
				end
				q = (acc + 16384) / 32768;
				if (q > 32768) begin
					q = 32768;
				end
				cos_q15[k] = int'(q);
			end
			foreach (ring[i]) begin
				ring[i] = '0;
			end
			wr_ptr    = '0;
			lfo_phase = '0;
			fx_on     = vib_pkg::RST_ENABLE;
			step      = vib_pkg::RST_PHASE_STEP;
			depth     = vib_pkg::RST_DEPTH;
			max_delay = vib_pkg::RST_MAX_DELAY;
			errors    = 0;
			wet_cnt   = 0;
			dry_cnt   = 0;
		endfunction

		function void set_reg(vib_pkg::cfg_idx_t idx, logic [31:0] val);
			case (idx)
				vib_pkg::CFG_ENABLE:     fx_on     = val[0];
				vib_pkg::CFG_PHASE_STEP: step      = val;
				vib_pkg::CFG_DEPTH:      depth     = val[16:0];
				vib_pkg::CFG_MAX_DELAY:  max_delay = val[9:0];
				default: ;
			endcase
		endfunction

		// Cosine of the phase, folded from the quarter-wave table
		function int lfo_cos(logic [31:0] ph);
			int idx;
			idx = int'(ph[29:22]);
			case (ph[31:30])
				2'd0:    return cos_q15[idx];
				2'd1:    return -cos_q15[TAB_SIZE - idx];
				2'd2:    return -cos_q15[idx];
				default: return cos_q15[TAB_SIZE - idx];
			endcase
		endfunction

		// Note an accepted sample: predict its output and advance the state
		function void take_sample(logic [15:0] smp);
			longint      dep;
			longint      half;
			longint      scaled;
			longint      dly;
			logic [15:0] res;
			if (fx_on) begin
				dep    = (depth > vib_pkg::DEPTH_FULL) ? 65536 : longint'(depth);
				half   = longint'(max_delay >> 1);
				scaled = (longint'(1) << 31) - dep * longint'(lfo_cos(lfo_phase));
				dly    = 1 + ((scaled * half) >>> 31);
				if (dly > DEPTH_RING - 1) begin
					dly = DEPTH_RING - 1;
				end
				res       = ring[10'(wr_ptr - 10'(dly))];
				lfo_phase = lfo_phase + step;
				wet_cnt++;
			end else begin
				res = smp;
				dry_cnt++;
			end
			ring[wr_ptr] = smp;
			wr_ptr       = wr_ptr + 10'd1;
			expected_out.push_back(res);
		endfunction

		// Compare one output item against the oldest prediction
		function void check_output(logic [15:0] got);
			logic [15:0] want;
			if (expected_out.size() == 0) begin
				$display("%0t: unexpected output item sample_out=%h", $time, got);
				errors++;
				return;
			end
			want = expected_out.pop_front();
			if (got !== want) begin
				$display("%0t: sample_out mismatch: expected %h actual %h", $time, want, got);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [vib_pkg::CFG_DATA_W-1:0] cfg_data;
	logic no_stall;
	int   stall_left;
	int   cycle_cnt;
	int   sent_cnt;
	int   setting_cnt;

	vib_in_if  in_ch ();
	vib_out_if out_ch ();

	vibrato_tracker tracker = new();

	lfo_modulated_delay_vibrato dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Stall the output side at random unless a steady stretch is running
	always @(posedge clk) begin
		if (stall_left != 0) begin
			out_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			out_ch.ready <= 1'b1;
			if (!no_stall && $urandom_range(0, 3) == 0) begin
				stall_left = pick_gap();
			end
		end
	end

	// Check every output item
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			tracker.check_output(out_ch.sample_out);
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("lfo_modulated_delay_vibrato test failed");
			$finish;
		end
	end

	// Offer one sample, hold it until taken, then maybe idle for a random gap
	task automatic send_sample(input logic [15:0] smp);
		int gap;
		in_ch.valid     <= 1'b1;
		in_ch.sample_in <= smp;
		do @(posedge clk); while (!in_ch.ready);
		tracker.take_sample(smp);
		sent_cnt++;
		gap = no_stall ? 0 : pick_gap();
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid and hold until every predicted output has arrived
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (tracker.expected_out.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input vib_pkg::cfg_idx_t idx, input logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		tracker.set_reg(idx, val);
	endtask

	// Write all four registers while the block is idle
	task automatic load_settings(input logic en, input logic [31:0] step,
			input logic [16:0] depth, input logic [9:0] max_delay);
		write_reg(vib_pkg::CFG_ENABLE, 32'(en));
		write_reg(vib_pkg::CFG_PHASE_STEP, step);
		write_reg(vib_pkg::CFG_DEPTH, 32'(depth));
		write_reg(vib_pkg::CFG_MAX_DELAY, 32'(max_delay));
		cfg_we <= 1'b0;
		setting_cnt++;
	endtask

	initial begin
		logic [31:0] step;
		logic [16:0] depth;
		logic [9:0]  max_delay;
		logic        en;
		int          run_len;
		arst_n          = 1'b0;
		in_ch.valid     = 1'b0;
		in_ch.sample_in = '0;
		out_ch.ready    = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = vib_pkg::CFG_ENABLE;
		cfg_data        = '0;
		no_stall        = 1'b0;
		stall_left      = 0;
		cycle_cnt       = 0;
		sent_cnt        = 0;
		setting_cnt     = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Bypass at reset defaults: samples pass straight through
		send_sample(16'h0000);
		send_sample(16'hFFFF);
		send_sample(16'h8000);
		send_sample(16'h7FFF);
		send_sample(16'h5555);
		send_sample(16'hAAAA);
		wait_drained();

		// Quarter-turn steps walk all four quadrants, full depth, odd max delay
		load_settings(1'b1, 32'h4000_0000, vib_pkg::DEPTH_FULL, 10'd1023);
		send_sample(16'h1234);
		send_sample(16'hFFFF);
		send_sample(16'h0001);
		send_sample(16'hFEDC);
		send_sample(16'h0000);
		send_sample(16'h8001);
		send_sample(16'h7FFE);
		send_sample(16'hC3C3);
		wait_drained();

		// Saturated depth, largest step, zero max delay
		load_settings(1'b1, 32'hFFFF_FFFF, 17'h1FFFF, 10'd0);
		send_sample(16'h0F0F);
		send_sample(16'hF0F0);
		send_sample(16'h3C3C);
		send_sample(16'hA5A5);
		wait_drained();

		// Frozen LFO, zero depth, smallest odd max delay
		load_settings(1'b1, 32'h0, 17'd0, 10'd1);
		send_sample(16'h0101);
		send_sample(16'hFEFE);
		send_sample(16'h4242);
		wait_drained();

		// Random settings, each followed by a run of random samples
		while (sent_cnt < ITEM_TARGET) begin
			en = ($urandom_range(0, 4) != 0);
			case ($urandom_range(0, 5))
				0:       step = 32'h0;
				1:       step = 32'hFFFF_FFFF;
				2, 3:    step = $urandom_range(0, 32'h0040_0000);
				default: step = $urandom;
			endcase
			case ($urandom_range(0, 7))
				0:       depth = 17'd0;
				1:       depth = vib_pkg::DEPTH_FULL;
				2:       depth = 17'($urandom_range(65537, 131071));
				default: depth = 17'($urandom_range(0, 65536));
			endcase
			case ($urandom_range(0, 7))
				0:       max_delay = 10'd0;
				1:       max_delay = 10'd1023;
				2:       max_delay = 10'd1022;
				default: max_delay = 10'($urandom_range(0, 1023));
			endcase
			load_settings(en, step, depth, max_delay);
			no_stall = ($urandom_range(0, 3) == 0);
			run_len  = $urandom_range(20, 120);
			repeat (run_len) send_sample(16'($urandom));
			no_stall = 1'b0;
			wait_drained();
		end

		// Let any stray output show up before the verdict
		repeat (SETTLE_CYC) @(posedge clk);
		$display("Sent %0d samples over %0d settings: %0d with effect on, %0d bypassed.",
			sent_cnt, setting_cnt, tracker.wet_cnt, tracker.dry_cnt);
		$display("Output mismatches or strays: %0d, predictions left over: %0d.",
			tracker.errors, tracker.expected_out.size());
		if (tracker.errors == 0 && tracker.expected_out.size() == 0) begin
			$display("lfo_modulated_delay_vibrato test passed");
		end else begin
			$display("lfo_modulated_delay_vibrato test failed");
		end
		$finish;
	end

endmodule
